FILE: sv/rtc_pkg.sv
// rtc_pkg: shared types, key table and microcode for the romanized to cyrillic block
// used by rtc_match and romanized_to_cyrillic_utf8_top; depends on nothing
`default_nettype none

package rtc_pkg;

  localparam int NKEYS = 37;
  localparam int KEY_SLOTS = 3;
  localparam int KIDXW = $clog2(NKEYS);

  localparam logic [7:0]  TEXT_LOW = 8'h20;
  localparam logic [10:0] ONE_BYTE_LIMIT = 11'h080;
  localparam logic [2:0]  LEAD_MARK = 3'b110;
  localparam logic [1:0]  CONT_MARK = 2'b10;

  // key bytes: first character in bits 7:0
  localparam logic [1:0] KEY_LEN [NKEYS] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
  };

  localparam logic [23:0] KEY_CHARS [NKEYS] = '{
    {16'h0, " "}, {16'h0, "+"}, {16'h0, "m"}, {16'h0, "p"}, {16'h0, "b"},
    {16'h0, "f"}, {16'h0, "v"},
    {8'h0, "_", "j"}, {8'h0, "e", "j"}, {8'h0, "a", "j"}, {8'h0, "o", "j"},
    {8'h0, "u", "j"}, {8'h0, "s", "j"}, {16'h0, "j"},
    {16'h0, "n"}, {16'h0, "d"}, {8'h0, "_", "t"}, {"s", "j", "t"},
    {8'h0, "s", "t"}, {16'h0, "t"},
    {16'h0, "s"}, {16'h0, "z"}, {16'h0, "l"}, {16'h0, "r"},
    {8'h0, "z", "h"}, {8'h0, "s", "h"},
    {16'h0, "k"}, {16'h0, "g"}, {16'h0, "x"}, {16'h0, "\""}, {16'h0, "'"},
    {16'h0, "i"}, {16'h0, "y"}, {16'h0, "e"}, {16'h0, "a"}, {16'h0, "o"},
    {16'h0, "u"}
  };

  localparam logic [10:0] KEY_CP [NKEYS] = '{
    11'h020, 11'h301, 11'h43c, 11'h43f, 11'h431, 11'h444, 11'h432,
    11'h439, 11'h435, 11'h44f, 11'h451, 11'h44e, 11'h449, 11'h439,
    11'h43d, 11'h434, 11'h442, 11'h447, 11'h446, 11'h442,
    11'h441, 11'h437, 11'h43b, 11'h440, 11'h436, 11'h448,
    11'h43a, 11'h433, 11'h445, 11'h44a, 11'h44c,
    11'h438, 11'h44b, 11'h44d, 11'h430, 11'h43e, 11'h443
  };

  typedef enum logic [1:0] {
    K_DATA     = 2'd0,
    K_ERROR    = 2'd1,
    K_LINE_END = 2'd2
  } rtc_kind_t;

  typedef struct packed {
    logic       hold;
    logic       nomatch;
    logic       onebyte;
    logic [1:0] len;
    logic [7:0] hi;
    logic [7:0] lo;
  } rtc_match_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_ACCEPT,
    A_EMIT_HI,
    A_EMIT_LO,
    A_EMIT_ERR,
    A_EMIT_END,
    A_FLUSH
  } rtc_act_t;

  typedef enum logic [2:0] {
    J_SEQ,
    J_ALWAYS,
    J_IF_SKIP,
    J_IF_HOLD,
    J_IF_NOMATCH,
    J_IF_ONEBYTE,
    J_IF_NOT_END
  } rtc_cond_t;

  typedef enum logic [3:0] {
    S_WAIT,
    S_DISPATCH,
    S_RESOLVE,
    S_CHECK,
    S_HI,
    S_LO,
    S_ERR,
    S_TAIL,
    S_END,
    S_FLUSH
  } rtc_step_t;

  typedef struct packed {
    rtc_act_t  act;
    rtc_cond_t cond;
    rtc_step_t target;
  } rtc_uword_t;

  // control store
  function automatic rtc_uword_t rtc_ucode(input rtc_step_t s);
    rtc_uword_t w;
    unique case (s)
      S_WAIT:     w = '{act: A_ACCEPT,   cond: J_SEQ,        target: S_WAIT};
      S_DISPATCH: w = '{act: A_NONE,     cond: J_IF_SKIP,    target: S_TAIL};
      S_RESOLVE:  w = '{act: A_NONE,     cond: J_IF_HOLD,    target: S_TAIL};
      S_CHECK:    w = '{act: A_NONE,     cond: J_IF_NOMATCH, target: S_ERR};
      S_HI:       w = '{act: A_EMIT_HI,  cond: J_IF_ONEBYTE, target: S_RESOLVE};
      S_LO:       w = '{act: A_EMIT_LO,  cond: J_ALWAYS,     target: S_RESOLVE};
      S_ERR:      w = '{act: A_EMIT_ERR, cond: J_SEQ,        target: S_WAIT};
      S_TAIL:     w = '{act: A_NONE,     cond: J_IF_NOT_END, target: S_FLUSH};
      S_END:      w = '{act: A_EMIT_END, cond: J_SEQ,        target: S_WAIT};
      S_FLUSH:    w = '{act: A_FLUSH,    cond: J_ALWAYS,     target: S_WAIT};
      default:    w = '{act: A_NONE,     cond: J_ALWAYS,     target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rtc_match.sv
// rtc_match: parallel compare of the pending bytes against the key table
// first hit in table order decides; depends on rtc_pkg
`default_nettype none

module rtc_match #(
  parameter int MAX_KEY_LEN = 3
) (
  input  wire logic [8*MAX_KEY_LEN-1:0]         pend,
  input  wire logic [$clog2(MAX_KEY_LEN+1)-1:0] count,
  input  wire logic                             at_end,
  output rtc_pkg::rtc_match_t                   result
);

  logic [8*(MAX_KEY_LEN+rtc_pkg::KEY_SLOTS)-1:0] padded;
  logic [rtc_pkg::NKEYS-1:0] hit;

  assign padded = {{(8*rtc_pkg::KEY_SLOTS){1'b0}}, pend};

  always_comb begin
    logic same;
    for (int i = 0; i < rtc_pkg::NKEYS; i++) begin
      same = 1'b1;
      for (int j = 0; j < rtc_pkg::KEY_SLOTS; j++) begin
        if (j < int'(rtc_pkg::KEY_LEN[i]) && j < int'(count)) begin
          if (rtc_pkg::KEY_CHARS[i][8*j +: 8] != padded[8*j +: 8]) begin
            same = 1'b0;
          end
        end
      end
      hit[i] = (int'(rtc_pkg::KEY_LEN[i]) <= MAX_KEY_LEN) && same &&
               ((int'(rtc_pkg::KEY_LEN[i]) <= int'(count)) || !at_end);
    end
  end

  always_comb begin
    logic                     got;
    logic [rtc_pkg::KIDXW-1:0] idx;
    logic [10:0]              cp;
    got = 1'b0;
    idx = '0;
    for (int i = 0; i < rtc_pkg::NKEYS; i++) begin
      if (!got && hit[i]) begin
        got = 1'b1;
        idx = rtc_pkg::KIDXW'(i);
      end
    end
    cp = rtc_pkg::KEY_CP[idx];
    result.len     = rtc_pkg::KEY_LEN[idx];
    result.nomatch = !got;
    result.hold    = (count == '0) ||
                     (got && (int'(rtc_pkg::KEY_LEN[idx]) > int'(count)));
    result.onebyte = cp < rtc_pkg::ONE_BYTE_LIMIT;
    result.hi      = result.onebyte ? cp[7:0] : {rtc_pkg::LEAD_MARK, cp[10:6]};
    result.lo      = {rtc_pkg::CONT_MARK, cp[5:0]};
  end

endmodule

`default_nettype wire

FILE: sv/romanized_to_cyrillic_utf8_top.sv
// romanized_to_cyrillic_utf8_top: microcoded transliterator, ascii in, utf-8 out
// depends on rtc_pkg and rtc_match
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | char_in
//   output  | out_valid | out_stall | out_byte, kind, last
//
// one item at a time: wait, dispatch, resolve, check, then a high byte emit per key, plus
// a low one for a two-byte code point, or an error emit; tail, line end and flush end it
// the step counter walks the control store, one step a cycle unless input or output blocks it
// results pass a one-deep stage and an output register; a stalled output holds the emit step
// reset clears the pending count, skip flag, stage and output valid; no clearing pass
`default_nettype none

module romanized_to_cyrillic_utf8_top #(
  parameter int MAX_KEY_LEN = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);

  localparam int CW = $clog2(MAX_KEY_LEN + 1);

  rtc_pkg::rtc_step_t  step;
  rtc_pkg::rtc_step_t  step_next;
  rtc_pkg::rtc_uword_t uw;
  rtc_pkg::rtc_match_t m;

  logic [8*MAX_KEY_LEN-1:0] pend;
  logic [CW-1:0]            count;
  logic                     skip;
  logic                     at_end;
  logic                     stg_valid;
  logic [7:0]               stg_byte;
  rtc_pkg::rtc_kind_t       stg_kind;

  logic line_end;
  logic out_free;
  logic blocked;
  logic take;
  logic emit_act;
  logic out_load;

  rtc_match #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_match (
    .pend  (pend),
    .count (count),
    .at_end(at_end),
    .result(m)
  );

  assign uw       = rtc_pkg::rtc_ucode(step);
  assign line_end = char_in[7] || (char_in < rtc_pkg::TEXT_LOW);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (uw.act != rtc_pkg::A_ACCEPT);
  // an emit pushes the staged result out ahead of the new one
  assign out_load = !blocked && emit_act && stg_valid;

  always_comb begin
    emit_act = 1'b0;
    blocked  = 1'b0;
    unique case (uw.act) inside
      rtc_pkg::A_ACCEPT: blocked = !in_valid;
      rtc_pkg::A_EMIT_HI, rtc_pkg::A_EMIT_LO, rtc_pkg::A_EMIT_ERR,
      rtc_pkg::A_EMIT_END, rtc_pkg::A_FLUSH: begin
        emit_act = 1'b1;
        blocked  = stg_valid && !out_free;
      end
      default: blocked = 1'b0;
    endcase
    unique case (uw.cond)
      rtc_pkg::J_SEQ:        take = 1'b0;
      rtc_pkg::J_ALWAYS:     take = 1'b1;
      rtc_pkg::J_IF_SKIP:    take = skip;
      rtc_pkg::J_IF_HOLD:    take = m.hold;
      rtc_pkg::J_IF_NOMATCH: take = m.nomatch;
      rtc_pkg::J_IF_ONEBYTE: take = m.onebyte;
      rtc_pkg::J_IF_NOT_END: take = !at_end;
      default:               take = 1'b1;
    endcase
    if (blocked) begin
      step_next = step;
    end else if (take) begin
      step_next = uw.target;
    end else begin
      step_next = rtc_pkg::rtc_step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= rtc_pkg::S_WAIT;
      count     <= '0;
      skip      <= 1'b0;
      at_end    <= 1'b0;
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_byte  <= stg_byte;
        kind      <= stg_kind;
        last      <= (uw.act == rtc_pkg::A_FLUSH);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (!blocked) begin
        step <= step_next;
        unique case (uw.act)
          rtc_pkg::A_ACCEPT: begin
            at_end <= line_end;
            if (!line_end && !skip && (int'(count) < MAX_KEY_LEN)) begin
              for (int j = 0; j < MAX_KEY_LEN; j++) begin
                if (count == CW'(j)) begin
                  pend[8*j +: 8] <= char_in;
                end
              end
              count <= count + CW'(1);
            end
          end
          rtc_pkg::A_EMIT_HI: begin
            stg_valid <= 1'b1;
            stg_byte  <= m.hi;
            stg_kind  <= rtc_pkg::K_DATA;
            if (m.onebyte) begin
              pend  <= pend >> {m.len, 3'b000};
              count <= count - CW'(m.len);
            end
          end
          rtc_pkg::A_EMIT_LO: begin
            stg_valid <= 1'b1;
            stg_byte  <= m.lo;
            stg_kind  <= rtc_pkg::K_DATA;
            pend      <= pend >> {m.len, 3'b000};
            count     <= count - CW'(m.len);
          end
          rtc_pkg::A_EMIT_ERR: begin
            stg_valid <= 1'b1;
            stg_byte  <= '0;
            stg_kind  <= rtc_pkg::K_ERROR;
            count     <= '0;
            skip      <= 1'b1;
          end
          rtc_pkg::A_EMIT_END: begin
            stg_valid <= 1'b1;
            stg_byte  <= '0;
            stg_kind  <= rtc_pkg::K_LINE_END;
            count     <= '0;
            skip      <= 1'b0;
          end
          rtc_pkg::A_FLUSH: stg_valid <= 1'b0;
          default: begin
          end
        endcase
      end
    end
  end

  // sequencer is back at the wait step only with the stage drained
  assert property (@(posedge clk) disable iff (rst)
    (step == rtc_pkg::S_WAIT) |-> !stg_valid)
    else $error("stage not drained at end of item");

  // a waiting buffer always leaves room for the next byte
  assert property (@(posedge clk) disable iff (rst)
    (step == rtc_pkg::S_WAIT) |-> (int'(count) < MAX_KEY_LEN))
    else $error("pending buffer full between items");

  // while the rest of a line is dropped nothing stays pending
  assert property (@(posedge clk) disable iff (rst)
    (step == rtc_pkg::S_WAIT && skip) |-> (count == '0))
    else $error("pending bytes while skipping");

  // a blocked emit holds the step counter
  assert property (@(posedge clk) disable iff (rst)
    (emit_act && stg_valid && out_valid && out_stall) |=> $stable(step))
    else $error("sequencer advanced past a blocked emit");

endmodule

`default_nettype wire
